// ===== rtl/core/mdpa_pkg.sv =====
// Shared constants, payload types and codes for the min-distance point admission block.
`timescale 1ns / 1ps

package mdpa_pkg;

  localparam int CAPACITY   = 1024;
  localparam int COORD_BITS = 16;

  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DIST_W   = 34;
  localparam int TARGET_W = 11;
  localparam int TRIES_W  = 16;
  localparam int RUN_W    = TRIES_W + 1;
  localparam int CFG_W    = DIST_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_COUNT    = 2'd0,
    REG_MIN_DISTANCE_SQ = 2'd1,
    REG_MAX_TRIES       = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FIN_PLACING = 2'd0,
    FIN_TARGET  = 2'd1,
    FIN_GAVE_UP = 2'd2
  } fin_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } point_t;

  typedef struct packed {
    logic              accepted;
    logic              nearest_found;
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] nearest_distance_sq;
    logic [CNT_W-1:0]  stored_count;
    logic [1:0]        status;
  } result_t;

  // Tag that travels alongside one stored point through the distance pipe
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage

// ===== rtl/core/mdpa_point_mem.sv =====
// Point table: one write port, one registered read port.
`timescale 1ns / 1ps

module mdpa_point_mem
  import mdpa_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  point_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output point_t           rd_data
);

  point_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/mdpa_dist.sv =====
// Three-stage squared-distance pipe: abs difference, square, sum with saturation.
`timescale 1ns / 1ps

module mdpa_dist
  import mdpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  scan_tag_t         tag_in,
  input  point_t            cand,
  input  point_t            pt,
  output scan_tag_t         tag_out,
  output logic [DIST_W-1:0] dist_sq
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int WIDE_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b);
    logic [DIFF_W-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
  endfunction

  scan_tag_t         tag1, tag2;
  logic [DIFF_W-1:0] ad_x, ad_y, ad_z;
  logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
  logic [WIDE_W-1:0] sum;

  assign sum = WIDE_W'(sq_x) + WIDE_W'(sq_y) + WIDE_W'(sq_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag2    <= '0;
      tag_out <= '0;
    end else begin
      tag1    <= tag_in;
      tag2    <= tag1;
      tag_out <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    ad_x <= abs_diff(cand.pos_x, pt.pos_x);
    ad_y <= abs_diff(cand.pos_y, pt.pos_y);
    ad_z <= abs_diff(cand.pos_z, pt.pos_z);
    sq_x <= SQ_W'(ad_x) * SQ_W'(ad_x);
    sq_y <= SQ_W'(ad_y) * SQ_W'(ad_y);
    sq_z <= SQ_W'(ad_z) * SQ_W'(ad_z);
    dist_sq <= (sum > WIDE_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
  end

endmodule

// ===== rtl/core/min_distance_point_admission.sv =====
// Top level: candidate admission controller around the point table and distance pipe.
`timescale 1ns / 1ps

// Each candidate is compared against every stored point, one table read per cycle
// through the single read port of the point table, in slot order. At most 1023
// stored points are scanned for an item (a table that reaches 1024 has met any
// target, so later items are not scanned); an item that meets an empty table or a
// finished block skips the scan and goes straight to the finish state. Items are
// handled one at a time; a new item is taken while the previous result still
// waits in the output register. The table needs no clearing after reset: only
// slots below the stored count are ever read. Configuration writes are expected
// only while the block is idle.
module min_distance_point_admission
  import mdpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  point_t               in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CMP_W = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

  function automatic logic [CMP_W-1:0] eff_target(input logic [TARGET_W-1:0] t);
    logic [CMP_W-1:0] v;
    v = CMP_W'(t);
    if (t == '0) begin
      v = CMP_W'(20);
    end
    if (v > CMP_W'(CAPACITY)) begin
      v = CMP_W'(CAPACITY);
    end
    return v;
  endfunction

  ctl_state_t state, state_next;

  logic [TARGET_W-1:0] target_count;
  logic [DIST_W-1:0]   min_distance_sq;
  logic [TRIES_W-1:0]  max_tries;

  logic [CNT_W-1:0]  point_count, cnt_next;
  logic [RUN_W-1:0]  reject_run, run_next;
  fin_state_t        finish_state, fin_next;

  point_t            cand;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  logic [DIST_W-1:0] best_dist;
  logic [CNT_W-1:0]  issue_cnt;
  logic              issue, issue_last, fin_go, target_met, wr_en;
  scan_tag_t         rd_tag, tag_out;
  point_t            rd_point;
  logic [DIST_W-1:0] dist_sq;
  result_t           res;

  assign target_met = CMP_W'(point_count) >= eff_target(target_count);
  assign issue_last = issue_cnt == (point_count - CNT_W'(1));

  mdpa_point_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (point_count[IDX_W-1:0]),
    .wr_data (cand),
    .rd_en   (issue),
    .rd_addr (issue_cnt[IDX_W-1:0]),
    .rd_data (rd_point)
  );

  mdpa_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (rd_tag),
    .cand    (cand),
    .pt      (rd_point),
    .tag_out (tag_out),
    .dist_sq (dist_sq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    issue      = 1'b0;
    fin_go     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (finish_state != FIN_PLACING || target_met || point_count == '0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tag_out.valid && tag_out.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          fin_go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outcome of the current item, applied when it moves to the output register
  always_comb begin
    res      = '0;
    cnt_next = point_count;
    run_next = reject_run;
    fin_next = finish_state;
    wr_en    = 1'b0;
    if (finish_state == FIN_PLACING) begin
      res.nearest_found       = found;
      res.nearest_index       = best_idx;
      res.nearest_distance_sq = best_dist;
      if (found && best_dist < min_distance_sq) begin
        run_next = reject_run + RUN_W'(1);
        if (run_next > RUN_W'(max_tries)) begin
          fin_next = FIN_GAVE_UP;
        end
      end else begin
        if (point_count < CNT_W'(CAPACITY)) begin
          wr_en        = fin_go;
          cnt_next     = point_count + CNT_W'(1);
          res.accepted = 1'b1;
        end
        run_next = '0;
        if (CMP_W'(cnt_next) >= eff_target(target_count)) begin
          fin_next = FIN_TARGET;
        end
      end
    end
    res.stored_count = cnt_next;
    res.status       = fin_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_count    <= TARGET_W'(20);
      min_distance_sq <= DIST_W'(5308416);
      max_tries       <= TRIES_W'(100);
      point_count     <= '0;
      reject_run      <= '0;
      finish_state    <= FIN_PLACING;
      out_valid       <= 1'b0;
      rd_tag          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_COUNT:    target_count    <= cfg_data[TARGET_W-1:0];
          REG_MIN_DISTANCE_SQ: min_distance_sq <= cfg_data[DIST_W-1:0];
          REG_MAX_TRIES:       max_tries       <= cfg_data[TRIES_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        cand      <= in_data;
        found     <= 1'b0;
        best_idx  <= '0;
        best_dist <= '0;
        issue_cnt <= '0;
        // target lowered to or below the current count
        if (finish_state == FIN_PLACING && target_met) begin
          finish_state <= FIN_TARGET;
        end
      end

      rd_tag.valid <= issue;
      rd_tag.last  <= issue_last;
      rd_tag.idx   <= issue_cnt[IDX_W-1:0];
      if (issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end

      // strict compare keeps the first slot on ties
      if (tag_out.valid && (!found || dist_sq < best_dist)) begin
        found     <= 1'b1;
        best_dist <= dist_sq;
        best_idx  <= tag_out.idx;
      end

      if (fin_go) begin
        out_valid    <= 1'b1;
        out_data     <= res;
        point_count  <= cnt_next;
        reject_run   <= run_next;
        finish_state <= fin_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_finish_sticky: assert property (@(posedge clk) disable iff (rst)
    (finish_state != FIN_PLACING) |=> (finish_state == $past(finish_state)))
    else $error("finish state changed after completion");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_tag.valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("table read outside a scan");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    tag_out.valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("distance result outside a scan");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (fin_go && res.accepted) |=> (point_count == $past(point_count) + CNT_W'(1)))
    else $error("stored count did not advance on admission");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fin_go |-> (cnt_next <= CNT_W'(CAPACITY)))
    else $error("stored count beyond capacity");

endmodule
